[design/wts_pkg.sv]
// Shared types and constants for the WAV to signed 8-bit mono converter.
// Used by wts_ctrl, wts_parser, the top level and the testbench; depends on nothing.
`default_nettype none

package wts_pkg;

	localparam int MAX_IN_CHANNELS_DEF = 8;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] RATE_RESET    = 32'd22050;
	localparam logic [15:0] CHAN_RESET    = 16'd1;
	localparam logic [15:0] DEPTH_RESET   = 16'd8;
	localparam logic [15:0] DEPTH_16      = 16'd16;
	localparam logic [15:0] FORMAT_PCM    = 16'd1;
	localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
	localparam logic [7:0]  SAMPLE_BIAS   = 8'd128;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK_ID,
		PH_CHUNK_SIZE,
		PH_FMT,
		PH_DATA,
		PH_SKIP,
		PH_PAD,
		PH_IGNORE
	} parse_phase_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_BAD_HEADER,
		STAT_UNSUPPORTED,
		STAT_NO_FRAMES
	} status_code_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_DIV,
		CS_SAMPLE,
		CS_STATUS
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic start_div;
		logic clear_file;
		logic emit_status;
	} ctrl_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic frame_end;
		logic div_done;
	} dp_stat_t;

endpackage

`default_nettype wire

[design/wts_divider.sv]
// Serial restoring divider: signed frame sum over channel count, one quotient
// bit per cycle, truncating toward zero and clamping to signed 8 bits.
`default_nettype none

module wts_divider #(
	parameter int SUM_W = 11,
	parameter int DEN_W = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0]        divisor,
	output logic                         done,
	output logic signed [7:0]            result
);

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [SUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [SUM_W-1:0] mag;
	logic [DEN_W:0]   rem_sh;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	assign mag      = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign fits     = rem_sh >= {1'b0, den_q};
	assign rem_next = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	// The mean of in-range samples never leaves the 8-bit range, but clamp anyway.
	always_comb begin
		if (neg_q) begin
			if (quo_q > SUM_W'(128)) begin
				result = -8'sd128;
			end else begin
				result = signed'(8'(~quo_q[7:0] + 8'd1));
			end
		end else begin
			if (quo_q > SUM_W'(127)) begin
				result = 8'sd127;
			end else begin
				result = signed'(quo_q[7:0]);
			end
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

[design/wts_parser.sv]
// Chunk walker and field capture: header check, chunk sizes, fmt fields,
// sample conversion, frame sums and the file status. Uses wts_pkg.
`default_nettype none

module wts_parser #(
	parameter int MAX_IN_CHANNELS = wts_pkg::MAX_IN_CHANNELS_DEF,
	parameter int SUM_W = 8 + $clog2(MAX_IN_CHANNELS),
	parameter int DEN_W = $clog2(MAX_IN_CHANNELS + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire wts_pkg::ctrl_cmd_t      cmd,
	input  wire logic [7:0]              file_byte,
	output logic                         frame_end,
	output logic signed [SUM_W-1:0]      div_sum,
	output logic [DEN_W-1:0]             div_den,
	output wts_pkg::status_code_t        status,
	output logic [31:0]                  rate,
	output logic [31:0]                  frames
);

	localparam int CI_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;

	// Byte offsets inside the fmt chunk body.
	localparam logic [3:0] OFF_TAG_LO   = 4'd0;
	localparam logic [3:0] OFF_TAG_HI   = 4'd1;
	localparam logic [3:0] OFF_CHAN_LO  = 4'd2;
	localparam logic [3:0] OFF_CHAN_HI  = 4'd3;
	localparam logic [3:0] OFF_RATE_0   = 4'd4;
	localparam logic [3:0] OFF_RATE_1   = 4'd5;
	localparam logic [3:0] OFF_RATE_2   = 4'd6;
	localparam logic [3:0] OFF_RATE_3   = 4'd7;
	localparam logic [3:0] OFF_DEPTH_LO = 4'd14;
	localparam logic [3:0] OFF_DEPTH_HI = 4'd15;
	localparam logic [3:0] IDX_TAG_END  = 4'd3;
	localparam logic [3:0] IDX_HDR_END  = 4'd11;

	wts_pkg::parse_phase_t phase_q, phase_d;
	wts_pkg::status_code_t err_q, err_d;
	logic [3:0]             idx_q, idx_d;
	logic [31:0]            tag_q, tag_d;
	logic [31:0]            remain_q, remain_d;
	logic                   pad_q, pad_d;
	logic [15:0]            fmt_q, fmt_d;
	logic [15:0]            chan_q, chan_d;
	logic [31:0]            rate_q, rate_d;
	logic [15:0]            depth_q, depth_d;
	logic [CI_W-1:0]        ch_idx_q, ch_idx_d;
	logic signed [SUM_W-1:0] sum_q, sum_d;
	logic [31:0]            frames_q, frames_d;

	logic [31:0]             tag_shift;
	logic [31:0]             size_val;
	logic                    format_ok;
	logic                    is_16;
	logic signed [7:0]       samp;
	logic                    samp_vld;
	logic signed [SUM_W-1:0] sum_new;
	logic                    last_chan;

	assign tag_shift = {tag_q[23:0], file_byte};
	assign format_ok = (fmt_q == wts_pkg::FORMAT_PCM) && (chan_q != 16'd0) &&
		(chan_q <= 16'(MAX_IN_CHANNELS)) &&
		((depth_q == wts_pkg::DEPTH_RESET) || (depth_q == wts_pkg::DEPTH_16)) &&
		(rate_q != 32'd0);
	assign is_16     = depth_q == wts_pkg::DEPTH_16;

	always_comb begin
		size_val = remain_q;
		size_val[idx_q[1:0]*8 +: 8] = file_byte;
	end

	// A 16-bit sample is complete on its odd byte, which is its signed high byte.
	assign samp      = is_16 ? signed'(file_byte) : signed'(file_byte ^ wts_pkg::SAMPLE_BIAS);
	assign samp_vld  = (phase_q == wts_pkg::PH_DATA) && (!is_16 || idx_q[0]);
	assign sum_new   = SUM_W'(sum_q + SUM_W'(samp));
	assign last_chan = (17'(ch_idx_q) + 17'd1) >= {1'b0, chan_q};
	assign frame_end = samp_vld && last_chan;
	assign div_sum   = sum_new;
	assign div_den   = chan_q[DEN_W-1:0];

	// Next parse phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			wts_pkg::PH_HEADER: begin
				if (idx_q == IDX_TAG_END && tag_shift != wts_pkg::TAG_RIFF) begin
					phase_d = wts_pkg::PH_IGNORE;
				end else if (idx_q == IDX_HDR_END) begin
					phase_d = (tag_shift == wts_pkg::TAG_WAVE) ? wts_pkg::PH_CHUNK_ID
						: wts_pkg::PH_IGNORE;
				end
			end
			wts_pkg::PH_CHUNK_ID: begin
				if (idx_q == IDX_TAG_END) begin
					phase_d = wts_pkg::PH_CHUNK_SIZE;
				end
			end
			wts_pkg::PH_CHUNK_SIZE: begin
				if (idx_q == IDX_TAG_END) begin
					if (size_val == 32'd0) begin
						phase_d = wts_pkg::PH_CHUNK_ID;
					end else if (tag_q == wts_pkg::TAG_FMT && size_val >= wts_pkg::FMT_MIN_SIZE) begin
						phase_d = wts_pkg::PH_FMT;
					end else if (tag_q == wts_pkg::TAG_DATA && format_ok) begin
						phase_d = wts_pkg::PH_DATA;
					end else begin
						phase_d = wts_pkg::PH_SKIP;
					end
				end
			end
			wts_pkg::PH_FMT, wts_pkg::PH_DATA, wts_pkg::PH_SKIP: begin
				if (remain_q == 32'd1) begin
					phase_d = pad_q ? wts_pkg::PH_PAD : wts_pkg::PH_CHUNK_ID;
				end else if (phase_q == wts_pkg::PH_FMT && idx_q >= OFF_DEPTH_HI) begin
					phase_d = wts_pkg::PH_SKIP;
				end
			end
			wts_pkg::PH_PAD: begin
				phase_d = wts_pkg::PH_CHUNK_ID;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Field and counter updates for the byte being taken.
	always_comb begin
		err_d    = err_q;
		idx_d    = idx_q;
		tag_d    = tag_q;
		remain_d = remain_q;
		pad_d    = pad_q;
		fmt_d    = fmt_q;
		chan_d   = chan_q;
		rate_d   = rate_q;
		depth_d  = depth_q;
		ch_idx_d = ch_idx_q;
		sum_d    = sum_q;
		frames_d = frames_q;
		case (phase_q)
			wts_pkg::PH_HEADER: begin
				tag_d = tag_shift;
				if ((idx_q == IDX_TAG_END && tag_shift != wts_pkg::TAG_RIFF) ||
						(idx_q == IDX_HDR_END && tag_shift != wts_pkg::TAG_WAVE)) begin
					if (err_q == wts_pkg::STAT_OK) begin
						err_d = wts_pkg::STAT_BAD_HEADER;
					end
				end else if (idx_q == IDX_HDR_END) begin
					idx_d = 4'd0;
				end else begin
					idx_d = 4'(idx_q + 4'd1);
				end
			end
			wts_pkg::PH_CHUNK_ID: begin
				tag_d = tag_shift;
				if (idx_q == IDX_TAG_END) begin
					idx_d    = 4'd0;
					remain_d = 32'd0;
				end else begin
					idx_d = 4'(idx_q + 4'd1);
				end
			end
			wts_pkg::PH_CHUNK_SIZE: begin
				remain_d = size_val;
				if (idx_q == IDX_TAG_END) begin
					idx_d = 4'd0;
					pad_d = size_val[0];
					if (size_val != 32'd0 &&
							!(tag_q == wts_pkg::TAG_FMT && size_val >= wts_pkg::FMT_MIN_SIZE) &&
							tag_q == wts_pkg::TAG_DATA) begin
						if (format_ok) begin
							ch_idx_d = '0;
							sum_d    = '0;
						end else if (err_q == wts_pkg::STAT_OK) begin
							err_d = wts_pkg::STAT_UNSUPPORTED;
						end
					end
				end else begin
					idx_d = 4'(idx_q + 4'd1);
				end
			end
			wts_pkg::PH_FMT, wts_pkg::PH_DATA, wts_pkg::PH_SKIP: begin
				if (phase_q == wts_pkg::PH_FMT) begin
					case (idx_q)
						OFF_TAG_LO:   fmt_d = {8'd0, file_byte};
						OFF_TAG_HI:   fmt_d[15:8] = file_byte;
						OFF_CHAN_LO:  chan_d = {8'd0, file_byte};
						OFF_CHAN_HI:  chan_d[15:8] = file_byte;
						OFF_RATE_0:   rate_d = {24'd0, file_byte};
						OFF_RATE_1:   rate_d[15:8] = file_byte;
						OFF_RATE_2:   rate_d[23:16] = file_byte;
						OFF_RATE_3:   rate_d[31:24] = file_byte;
						OFF_DEPTH_LO: depth_d = {8'd0, file_byte};
						OFF_DEPTH_HI: depth_d[15:8] = file_byte;
						default:      fmt_d = fmt_q;
					endcase
					if (idx_q < OFF_DEPTH_HI) begin
						idx_d = 4'(idx_q + 4'd1);
					end
				end else if (phase_q == wts_pkg::PH_DATA) begin
					if (is_16) begin
						idx_d = idx_q[0] ? 4'd0 : 4'd1;
					end
					if (samp_vld) begin
						if (last_chan) begin
							ch_idx_d = '0;
							sum_d    = '0;
							if (frames_q != '1) begin
								frames_d = 32'(frames_q + 32'd1);
							end
						end else begin
							ch_idx_d = CI_W'(ch_idx_q + 1'b1);
							sum_d    = sum_new;
						end
					end
				end
				remain_d = 32'(remain_q - 32'd1);
				if (remain_q == 32'd1) begin
					idx_d = 4'd0;
				end
			end
			wts_pkg::PH_PAD: begin
				pad_d = 1'b0;
				idx_d = 4'd0;
			end
			default: begin
				idx_d = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wts_pkg::PH_HEADER;
			err_q    <= wts_pkg::STAT_OK;
			idx_q    <= '0;
			tag_q    <= '0;
			remain_q <= '0;
			pad_q    <= 1'b0;
			fmt_q    <= '0;
			chan_q   <= wts_pkg::CHAN_RESET;
			rate_q   <= wts_pkg::RATE_RESET;
			depth_q  <= wts_pkg::DEPTH_RESET;
			ch_idx_q <= '0;
			sum_q    <= '0;
			frames_q <= '0;
		end else if (cmd.clear_file) begin
			phase_q  <= wts_pkg::PH_HEADER;
			err_q    <= wts_pkg::STAT_OK;
			idx_q    <= '0;
			tag_q    <= '0;
			remain_q <= '0;
			pad_q    <= 1'b0;
			fmt_q    <= '0;
			chan_q   <= wts_pkg::CHAN_RESET;
			rate_q   <= wts_pkg::RATE_RESET;
			depth_q  <= wts_pkg::DEPTH_RESET;
			ch_idx_q <= '0;
			sum_q    <= '0;
			frames_q <= '0;
		end else if (cmd.take) begin
			phase_q  <= phase_d;
			err_q    <= err_d;
			idx_q    <= idx_d;
			tag_q    <= tag_d;
			remain_q <= remain_d;
			pad_q    <= pad_d;
			fmt_q    <= fmt_d;
			chan_q   <= chan_d;
			rate_q   <= rate_d;
			depth_q  <= depth_d;
			ch_idx_q <= ch_idx_d;
			sum_q    <= sum_d;
			frames_q <= frames_d;
		end
	end

	// A file that never got past its header reports a bad header.
	always_comb begin
		if (err_q == wts_pkg::STAT_BAD_HEADER || phase_q == wts_pkg::PH_HEADER) begin
			status = wts_pkg::STAT_BAD_HEADER;
		end else if (err_q == wts_pkg::STAT_UNSUPPORTED) begin
			status = wts_pkg::STAT_UNSUPPORTED;
		end else if (frames_q == 32'd0) begin
			status = wts_pkg::STAT_NO_FRAMES;
		end else begin
			status = wts_pkg::STAT_OK;
		end
	end

	assign rate   = rate_q;
	assign frames = frames_q;

endmodule

`default_nettype wire

[design/wts_ctrl.sv]
// Controller state machine: takes bytes, waits for the divider, and hands
// out sample and status results in order. Uses wts_pkg.
`default_nettype none

module wts_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               end_of_file,
	input  wire logic               out_stall,
	input  wire wts_pkg::dp_stat_t  stat,
	output logic                    in_stall,
	output logic                    out_valid,
	output wts_pkg::ctrl_cmd_t      cmd
);

	wts_pkg::ctrl_state_t state_q, state_d;
	logic                 eof_q;
	logic                 take;

	assign take = (state_q == wts_pkg::CS_IDLE) && in_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wts_pkg::CS_IDLE: begin
				if (take) begin
					if (stat.frame_end) begin
						state_d = wts_pkg::CS_DIV;
					end else if (end_of_file) begin
						state_d = wts_pkg::CS_STATUS;
					end
				end
			end
			wts_pkg::CS_DIV: begin
				if (stat.div_done) begin
					state_d = wts_pkg::CS_SAMPLE;
				end
			end
			wts_pkg::CS_SAMPLE: begin
				if (!out_stall) begin
					state_d = eof_q ? wts_pkg::CS_STATUS : wts_pkg::CS_IDLE;
				end
			end
			wts_pkg::CS_STATUS: begin
				if (!out_stall) begin
					state_d = wts_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = wts_pkg::CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall        = state_q != wts_pkg::CS_IDLE;
		out_valid       = (state_q == wts_pkg::CS_SAMPLE) || (state_q == wts_pkg::CS_STATUS);
		cmd.take        = take;
		cmd.start_div   = take && stat.frame_end;
		cmd.clear_file  = (state_q == wts_pkg::CS_STATUS) && !out_stall;
		cmd.emit_status = state_q == wts_pkg::CS_STATUS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wts_pkg::CS_IDLE;
			eof_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				eof_q <= end_of_file;
			end
		end
	end

endmodule

`default_nettype wire

[design/wav_to_s8_mono_converter.sv]
// Top level of the WAV to signed 8-bit mono converter: controller, parser
// and divider. Uses wts_pkg, wts_ctrl, wts_parser and wts_divider.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | file_byte, end_of_file
//  out     | out_valid | out_stall | item_kind, sample_value, status_code,
//          |           |           | sample_rate, frame_count, last_item
//
// A byte that completes no frame is simply taken. A byte that completes a
// frame also starts the one-bit-per-cycle divider, and its sample is then
// held for as long as out_stall is high.
// The byte marked end_of_file is followed by a status item, which out_stall can also hold.
// in_stall is high from a frame's end or file end until its results are taken.
// Reset is asynchronous and needs no clearing pass; after a status item the
// block is back in its reset state.
`default_nettype none

module wav_to_s8_mono_converter #(
	parameter int MAX_IN_CHANNELS = wts_pkg::MAX_IN_CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  file_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             item_kind,
	output logic signed [7:0] sample_value,
	output logic [1:0]       status_code,
	output logic [31:0]      sample_rate,
	output logic [31:0]      frame_count,
	output logic             last_item
);

	localparam int SUM_W = 8 + $clog2(MAX_IN_CHANNELS);
	localparam int DEN_W = $clog2(MAX_IN_CHANNELS + 1);

	wts_pkg::ctrl_cmd_t    cmd;
	wts_pkg::dp_stat_t     stat;
	wts_pkg::status_code_t status;
	logic                  frame_end;
	logic                  div_done;
	logic signed [SUM_W-1:0] div_sum;
	logic [DEN_W-1:0]      div_den;
	logic signed [7:0]     div_result;
	logic [31:0]           rate;
	logic [31:0]           frames;

	assign stat.frame_end = frame_end;
	assign stat.div_done  = div_done;

	wts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.end_of_file (end_of_file),
		.out_stall   (out_stall),
		.stat        (stat),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd)
	);

	wts_parser #(
		.MAX_IN_CHANNELS (MAX_IN_CHANNELS),
		.SUM_W           (SUM_W),
		.DEN_W           (DEN_W)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.file_byte (file_byte),
		.frame_end (frame_end),
		.div_sum   (div_sum),
		.div_den   (div_den),
		.status    (status),
		.rate      (rate),
		.frames    (frames)
	);

	wts_divider #(
		.SUM_W (SUM_W),
		.DEN_W (DEN_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (div_sum),
		.divisor  (div_den),
		.done     (div_done),
		.result   (div_result)
	);

	// Rate and count are reported only when the file came out clean.
	always_comb begin
		item_kind    = cmd.emit_status ? wts_pkg::KIND_STATUS : wts_pkg::KIND_SAMPLE;
		sample_value = cmd.emit_status ? 8'sd0 : div_result;
		status_code  = cmd.emit_status ? status : wts_pkg::STAT_OK;
		sample_rate  = (cmd.emit_status && status == wts_pkg::STAT_OK) ? rate : 32'd0;
		frame_count  = (cmd.emit_status && status == wts_pkg::STAT_OK) ? frames : 32'd0;
		last_item    = cmd.emit_status;
	end

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> ##(SUM_W + 1) div_done)
		else $error("divider did not finish in the expected number of cycles");

	a_no_take_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input request taken while a result is pending");

	a_ok_has_frames: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind == wts_pkg::KIND_STATUS && status_code == wts_pkg::STAT_OK)
		|-> frame_count != 32'd0)
		else $error("ok status reported with no frames");

	a_clear_after_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_item) |=> !out_valid && !in_stall)
		else $error("block not idle after the status request");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for wav_to_s8_mono_converter: feeds WAV files byte by byte and
// compares each sample and status item with a built-in parser and downmix predictor.
// Depends on wts_pkg and the converter RTL only.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wts_pkg::*;

	localparam int          MAX_CH  = MAX_IN_CHANNELS_DEF;
	localparam logic [15:0] DEPTH_8 = 16'd8;

	typedef struct packed {
		logic [7:0] value;
		logic       eof;
	} file_byte_t;

	typedef struct packed {
		logic               kind;
		logic signed [7:0]  sample;
		status_code_t       status;
		logic [31:0]        rate;
		logic [31:0]        count;
		logic               last;
	} mono_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] file_byte = 8'd0;
	logic end_of_file = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic item_kind;
	logic signed [7:0] sample_value;
	logic [1:0] status_code;
	logic [31:0] sample_rate;
	logic [31:0] frame_count;
	logic last_item;

	wav_to_s8_mono_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.file_byte(file_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_kind(item_kind),
		.sample_value(sample_value),
		.status_code(status_code),
		.sample_rate(sample_rate),
		.frame_count(frame_count),
		.last_item(last_item)
	);

	file_byte_t wav_byte_fifo[$];
	mono_item_t expected_mono_items[$];
	logic [7:0] wav_image[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_queued = 0;
	int bytes_taken = 0;
	int samples_seen = 0;
	int status_seen = 0;
	int error_count = 0;

	// Predicted parser state.
	parse_phase_t      phase_r;
	logic [3:0]        idx_r;
	logic [31:0]       tag_r;
	logic [31:0]       remain_r;
	logic              pad_r;
	logic [15:0]       fmt_tag_r;
	logic [15:0]       chans_r;
	logic [31:0]       rate_r;
	logic [15:0]       depth_r;
	logic [3:0]        chan_idx_r;
	logic [7:0]        low_hold_r;
	logic signed [11:0] sum_r;
	logic [31:0]       frames_r;
	status_code_t      err_r;

	function automatic void clear_parser();
		phase_r    = PH_HEADER;
		idx_r      = '0;
		tag_r      = '0;
		remain_r   = '0;
		pad_r      = 1'b0;
		fmt_tag_r  = '0;
		chans_r    = CHAN_RESET;
		rate_r     = RATE_RESET;
		depth_r    = DEPTH_RESET;
		chan_idx_r = '0;
		low_hold_r = '0;
		sum_r      = '0;
		frames_r   = '0;
		err_r      = STAT_OK;
	endfunction

	function automatic void flag_status(status_code_t code);
		if (err_r == STAT_OK)
			err_r = code;
	endfunction

	function automatic logic format_supported();
		return fmt_tag_r == FORMAT_PCM && chans_r >= 16'd1 && chans_r <= 16'(MAX_CH) &&
			(depth_r == DEPTH_8 || depth_r == DEPTH_16) && rate_r != 32'd0;
	endfunction

	// Adds one channel to the frame and emits the averaged sample when the frame is full.
	function automatic void mix_sample(int s);
		int avg;
		mono_item_t item;
		sum_r = 12'(sum_r + s);
		if ({28'd0, chan_idx_r} + 32'd1 >= {16'd0, chans_r}) begin
			avg = int'(sum_r) / int'(chans_r);
			if (avg < -128)
				avg = -128;
			if (avg > 127)
				avg = 127;
			item = '{KIND_SAMPLE, 8'(avg), STAT_OK, 32'd0, 32'd0, 1'b0};
			expected_mono_items.push_back(item);
			if (frames_r != '1)
				frames_r++;
			chan_idx_r = '0;
			sum_r = '0;
		end else begin
			chan_idx_r++;
		end
	endfunction

	function automatic void parse_wav_byte(logic [7:0] b, logic eof);
		status_code_t st;
		mono_item_t item;
		case (phase_r)
			PH_HEADER: begin
				tag_r = {tag_r[23:0], b};
				if (idx_r == 4'd3 && tag_r != TAG_RIFF) begin
					flag_status(STAT_BAD_HEADER);
					phase_r = PH_IGNORE;
				end else if (idx_r == 4'd11) begin
					if (tag_r != TAG_WAVE) begin
						flag_status(STAT_BAD_HEADER);
						phase_r = PH_IGNORE;
					end else begin
						phase_r = PH_CHUNK_ID;
						idx_r = '0;
					end
				end else begin
					idx_r++;
				end
			end
			PH_CHUNK_ID: begin
				tag_r = {tag_r[23:0], b};
				idx_r++;
				if (idx_r >= 4'd4) begin
					idx_r = '0;
					remain_r = '0;
					phase_r = PH_CHUNK_SIZE;
				end
			end
			PH_CHUNK_SIZE: begin
				remain_r = remain_r | ({24'd0, b} << {idx_r[1:0], 3'b000});
				idx_r++;
				if (idx_r >= 4'd4) begin
					idx_r = '0;
					pad_r = remain_r[0];
					if (remain_r == 32'd0) begin
						phase_r = PH_CHUNK_ID;
					end else if (tag_r == TAG_FMT && remain_r >= FMT_MIN_SIZE) begin
						phase_r = PH_FMT;
					end else if (tag_r == TAG_DATA) begin
						if (format_supported()) begin
							chan_idx_r = '0;
							sum_r = '0;
							phase_r = PH_DATA;
						end else begin
							flag_status(STAT_UNSUPPORTED);
							phase_r = PH_SKIP;
						end
					end else begin
						phase_r = PH_SKIP;
					end
				end
			end
			PH_FMT, PH_DATA, PH_SKIP: begin
				if (phase_r == PH_FMT) begin
					case (idx_r)
						4'd0: fmt_tag_r = {8'd0, b};
						4'd1: fmt_tag_r[15:8] = b;
						4'd2: chans_r = {8'd0, b};
						4'd3: chans_r[15:8] = b;
						4'd4: rate_r = {24'd0, b};
						4'd5: rate_r[15:8] = b;
						4'd6: rate_r[23:16] = b;
						4'd7: rate_r[31:24] = b;
						4'd14: depth_r = {8'd0, b};
						4'd15: depth_r[15:8] = b;
						default: ;
					endcase
					if (idx_r >= 4'd15)
						phase_r = PH_SKIP;
					else
						idx_r++;
				end else if (phase_r == PH_DATA) begin
					// A 16-bit sample keeps only its high byte.
					if (depth_r == DEPTH_16) begin
						if (!idx_r[0]) begin
							low_hold_r = b;
							idx_r = 4'd1;
						end else begin
							idx_r = '0;
							mix_sample(int'($signed(b)));
						end
					end else begin
						mix_sample(int'(b) - int'(SAMPLE_BIAS));
					end
				end
				remain_r--;
				if (remain_r == 32'd0) begin
					idx_r = '0;
					phase_r = pad_r ? PH_PAD : PH_CHUNK_ID;
				end
			end
			PH_PAD: begin
				pad_r = 1'b0;
				idx_r = '0;
				phase_r = PH_CHUNK_ID;
			end
			default: ;
		endcase

		if (eof) begin
			if (err_r == STAT_BAD_HEADER || phase_r == PH_HEADER)
				st = STAT_BAD_HEADER;
			else if (err_r == STAT_UNSUPPORTED)
				st = STAT_UNSUPPORTED;
			else if (frames_r == 32'd0)
				st = STAT_NO_FRAMES;
			else
				st = STAT_OK;
			if (st == STAT_OK)
				item = '{KIND_STATUS, 8'sd0, st, rate_r, frames_r, 1'b1};
			else
				item = '{KIND_STATUS, 8'sd0, st, 32'd0, 32'd0, 1'b1};
			expected_mono_items.push_back(item);
			clear_parser();
		end
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// File image builders.
	function automatic void put_tag(logic [31:0] tag);
		for (int i = 3; i >= 0; i--)
			wav_image.push_back(tag[i*8 +: 8]);
	endfunction

	function automatic void put_le(logic [31:0] v, int nbytes);
		for (int i = 0; i < nbytes; i++)
			wav_image.push_back(v[i*8 +: 8]);
	endfunction

	function automatic logic [7:0] sample_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h80;
			2: return 8'hFF;
			3: return 8'h7F;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic void put_riff_head();
		wav_image.delete();
		put_tag(TAG_RIFF);
		put_le($urandom(), 4);
		put_tag(TAG_WAVE);
	endfunction

	function automatic void put_chunk(logic [31:0] id, int len);
		put_tag(id);
		put_le(len, 4);
		repeat (len)
			wav_image.push_back(sample_byte());
		if (len % 2)
			wav_image.push_back(8'($urandom()));
	endfunction

	function automatic void put_fmt(logic [15:0] tag, logic [15:0] chans, logic [15:0] depth,
			logic [31:0] rate, int len);
		put_tag(TAG_FMT);
		put_le(len, 4);
		if (len >= 16) begin
			put_le(tag, 2);
			put_le(chans, 2);
			put_le(rate, 4);
			put_le($urandom(), 4);
			put_le($urandom(), 2);
			put_le(depth, 2);
			repeat (len - 16)
				wav_image.push_back(8'($urandom()));
		end else begin
			repeat (len)
				wav_image.push_back(8'($urandom()));
		end
		if (len % 2)
			wav_image.push_back(8'($urandom()));
	endfunction

	// Sends the first keep bytes of the image (all of it if keep is zero) as one file.
	function automatic void queue_image(int keep);
		int n;
		file_byte_t fb;
		n = (keep <= 0 || keep > wav_image.size()) ? wav_image.size() : keep;
		for (int i = 0; i < n; i++) begin
			fb.value = wav_image[i];
			fb.eof = (i == n - 1);
			wav_byte_fifo.push_back(fb);
		end
		bytes_queued += n;
	endfunction

	function automatic void queue_random_file();
		logic [15:0] chans;
		logic [15:0] depth;
		logic [15:0] tag;
		logic [31:0] rate;
		int fmt_len;
		// A few files are plain noise, some of them with a correct first tag.
		if ($urandom_range(0, 99) < 8) begin
			wav_image.delete();
			if ($urandom_range(0, 1))
				put_tag(TAG_RIFF);
			repeat ($urandom_range(1, 16))
				wav_image.push_back(8'($urandom()));
			queue_image(0);
			return;
		end
		put_riff_head();
		if ($urandom_range(0, 9) == 0)
			put_chunk($urandom(), $urandom_range(0, 9));
		if ($urandom_range(0, 9) == 0)
			put_chunk(TAG_DATA, $urandom_range(1, 8));
		case ($urandom_range(0, 19))
			0: chans = 16'd0;
			1: chans = 16'(MAX_CH + 1);
			2: chans = 16'($urandom());
			3, 4, 5, 6: chans = 16'($urandom_range(1, MAX_CH));
			default: chans = 16'($urandom_range(1, 2));
		endcase
		depth = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
			($urandom_range(0, 1) ? DEPTH_16 : DEPTH_8);
		tag = ($urandom_range(0, 24) == 0) ? 16'($urandom()) : FORMAT_PCM;
		rate = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
		case ($urandom_range(0, 9))
			0: fmt_len = 18;
			1: fmt_len = 40;
			2: fmt_len = 15;
			default: fmt_len = 16;
		endcase
		put_fmt(tag, chans, depth, rate, fmt_len);
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 4) == 0)
				put_chunk($urandom(), $urandom_range(0, 5));
			put_chunk(TAG_DATA, $urandom_range(0, 40));
		end
		queue_image(($urandom_range(0, 99) < 15) ? $urandom_range(1, wav_image.size()) : 0);
	endfunction

	task automatic wait_for_drain();
		while (wav_byte_fifo.size() != 0 || in_valid || expected_mono_items.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// Driver: a new request is presented only once the current one has been taken.
	file_byte_t next_byte;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (wav_byte_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_byte = wav_byte_fifo.pop_front();
				in_valid <= 1'b1;
				file_byte <= next_byte.value;
				end_of_file <= next_byte.eof;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Monitor: predicts on every accepted byte, then checks any accepted result.
	mono_item_t want_item;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_wav_byte(file_byte, end_of_file);
				bytes_taken++;
			end
			if (out_valid && !out_stall) begin
				if (expected_mono_items.size() == 0) begin
					$error("unexpected result: item_kind %0d sample_value %0d status_code %0d",
						item_kind, sample_value, status_code);
					error_count++;
				end else begin
					want_item = expected_mono_items.pop_front();
					check_field("item_kind", want_item.kind, item_kind);
					check_field("sample_value", want_item.sample, sample_value);
					check_field("status_code", want_item.status, status_code);
					check_field("sample_rate", want_item.rate, sample_rate);
					check_field("frame_count", want_item.count, frame_count);
					check_field("last_item", want_item.last, last_item);
				end
				if (item_kind == KIND_STATUS)
					status_seen++;
				else
					samples_seen++;
			end
		end
	end

	initial begin
		int target;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 31 : 0;
			if (phase == 0) begin
				// Header cut short, then a wrong RIFF tag with trailing bytes ignored.
				wav_image.delete();
				put_tag(TAG_RIFF);
				queue_image(3);
				wav_image.delete();
				put_tag(TAG_RIFF ^ 32'd1);
				put_le($urandom(), 4);
				queue_image(0);
				// Wrong WAVE tag, then a bare header with no chunks at all.
				wav_image.delete();
				put_tag(TAG_RIFF);
				put_le(32'd36, 4);
				put_tag(TAG_WAVE ^ 32'h100);
				queue_image(0);
				put_riff_head();
				queue_image(0);
				// Data ahead of fmt is rejected; the later data still converts.
				put_riff_head();
				put_chunk(TAG_DATA, 3);
				put_fmt(FORMAT_PCM, 16'd1, DEPTH_8, 32'd8000, 16);
				put_chunk(TAG_DATA, 4);
				queue_image(0);
				// A fmt chunk too short to count leaves the format unusable.
				put_riff_head();
				put_fmt(FORMAT_PCM, 16'd1, DEPTH_8, 32'd8000, 14);
				put_chunk(TAG_DATA, 2);
				queue_image(0);
				// Empty and odd-sized foreign chunks, an empty data chunk, 8-bit extremes.
				put_riff_head();
				put_chunk(32'h4C49_5354, 0);
				put_chunk(32'h4A55_4E4B, 3);
				put_fmt(FORMAT_PCM, 16'd1, DEPTH_8, 32'hFFFF_FFFF, 18);
				put_chunk(TAG_DATA, 0);
				put_tag(TAG_DATA);
				put_le(32'd4, 4);
				wav_image.push_back(8'h00);
				wav_image.push_back(8'h80);
				wav_image.push_back(8'hFF);
				wav_image.push_back(8'h7F);
				queue_image(0);
				// 16-bit stereo extremes, a dropped partial frame, and a sum of -1 over two.
				put_riff_head();
				put_fmt(FORMAT_PCM, 16'd2, DEPTH_16, 32'd44100, 16);
				put_tag(TAG_DATA);
				put_le(32'd9, 4);
				for (int i = 0; i < 4; i++)
					wav_image.push_back(i[0] ? 8'h80 : 8'h00);
				for (int i = 0; i < 4; i++)
					wav_image.push_back(i[0] ? 8'h7F : 8'hFF);
				wav_image.push_back(8'h55);
				wav_image.push_back(8'hAA);
				put_tag(TAG_DATA);
				put_le(32'd4, 4);
				wav_image.push_back(8'h00);
				wav_image.push_back(8'hFF);
				wav_image.push_back(8'h00);
				wav_image.push_back(8'h00);
				queue_image(0);
				// Three channels truncating toward zero; the file ends on a frame's last byte.
				put_riff_head();
				put_fmt(FORMAT_PCM, 16'd3, DEPTH_8, 32'd11025, 16);
				put_tag(TAG_DATA);
				put_le(32'd6, 4);
				wav_image.push_back(8'h7F);
				wav_image.push_back(8'h80);
				wav_image.push_back(8'h80);
				repeat (3)
					wav_image.push_back(8'h00);
				queue_image(0);
				// Widest supported frame.
				put_riff_head();
				put_fmt(FORMAT_PCM, 16'(MAX_CH), DEPTH_16, 32'd48000, 16);
				put_chunk(TAG_DATA, 4 * MAX_CH);
				queue_image(0);
				// Each kind of unsupported format.
				for (int k = 0; k < 5; k++) begin
					put_riff_head();
					put_fmt((k == 0) ? 16'd3 : FORMAT_PCM,
						(k == 1) ? 16'd0 : (k == 2) ? 16'(MAX_CH + 1) : 16'd2,
						(k == 3) ? 16'd24 : DEPTH_16,
						(k == 4) ? 32'd0 : 32'd44100, 16);
					put_chunk(TAG_DATA, 4);
					queue_image(0);
				end
				// File ends partway through the fmt chunk.
				put_riff_head();
				put_fmt(FORMAT_PCM, 16'd2, DEPTH_16, 32'd32000, 16);
				queue_image(26);
			end
			target = bytes_queued + 300;
			while (bytes_queued < target)
				queue_random_file();
			// The sender holds off here until every expected result is back.
			wait_for_drain();
		end

		repeat (40) @(posedge clk);
		$display("Run covered %0d file bytes giving %0d samples and %0d status items,",
			bytes_taken, samples_seen, status_seen);
		$display("across three idling mixes on the request and result sides.");
		if (error_count == 0) begin
			$display("wav_to_s8_mono_converter test passed");
		end else begin
			$display("wav_to_s8_mono_converter test failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("wav_to_s8_mono_converter test failed");
		$finish;
	end

endmodule

`default_nettype wire
